FILE: rtl/command_line_normalizer_unit_assert.svh
// Assertion macros shared by the command line normaliser checker.
`ifndef COMMAND_LINE_NORMALIZER_UNIT_ASSERT_SVH
`define COMMAND_LINE_NORMALIZER_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define CLN_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("command line normaliser: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define CLN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("command line normaliser: next-cycle check failed");

`endif

FILE: rtl/cln_pkg.sv
// Package with byte constants, classes and types of the command line normaliser.
`default_nettype none
package cln_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Byte classes.
  localparam logic [2:0] CLS_PLAIN = 3'd0;
  localparam logic [2:0] CLS_END   = 3'd1;
  localparam logic [2:0] CLS_DROP  = 3'd2;
  localparam logic [2:0] CLS_SEP   = 3'd3;
  localparam logic [2:0] CLS_PASS  = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] count;
    logic       pending;
    logic       stopped;
  } decode_t;

  function automatic logic [2:0] byte_class(input logic [7:0] b);
    logic [2:0] cls;
    case (b) inside
      CH_NUL:                                           cls = CLS_END;
      CH_DQUOTE, CH_SQUOTE, CH_BSLASH, CH_CARET:        cls = CLS_DROP;
      CH_SPACE, CH_COMMA, CH_SEMI, CH_TAB, CH_CR, CH_LF: cls = CLS_SEP;
      CH_SLASH, CH_LPAREN:                              cls = CLS_PASS;
      default:                                          cls = CLS_PLAIN;
    endcase
    return cls;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r = b + CASE_OFFSET;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cln_decode.sv
// Per-byte decode: classifies one byte and forms up to two results and the next state.
`default_nettype none
module cln_decode (
  input  logic [7:0]       in_byte,
  input  logic             end_of_string,
  input  logic             space_pending,
  input  logic             string_stopped,
  output cln_pkg::decode_t dec
);
  import cln_pkg::*;

  localparam res_t EMPTY_RES = '{data: CH_NUL, valid: 1'b0, last: 1'b0};

  always_comb begin
    dec         = '0;
    dec.r0      = EMPTY_RES;
    dec.r1      = EMPTY_RES;
    dec.count   = 2'd0;
    dec.pending = space_pending;
    dec.stopped = string_stopped;

    if (!string_stopped) begin
      unique case (byte_class(in_byte))
        CLS_END: begin
          dec.stopped = 1'b1;
        end
        CLS_DROP: begin
        end
        CLS_SEP: begin
          dec.pending = 1'b1;
        end
        CLS_PASS: begin
          dec.pending = 1'b0;
          dec.r0      = '{data: in_byte, valid: 1'b1, last: 1'b0};
          dec.count   = 2'd1;
        end
        default: begin
          dec.pending = 1'b0;
          if (space_pending) begin
            dec.r0    = '{data: CH_SPACE, valid: 1'b1, last: 1'b0};
            dec.r1    = '{data: to_lower(in_byte), valid: 1'b1, last: 1'b0};
            dec.count = 2'd2;
          end else begin
            dec.r0    = '{data: to_lower(in_byte), valid: 1'b1, last: 1'b0};
            dec.count = 2'd1;
          end
        end
      endcase
    end

    // A space can only still be pending here if nothing was emitted.
    if (end_of_string) begin
      if (dec.pending) begin
        dec.r0    = '{data: CH_SPACE, valid: 1'b1, last: 1'b1};
        dec.count = 2'd1;
      end else if (dec.count == 2'd2) begin
        dec.r1.last = 1'b1;
      end else if (dec.count == 2'd1) begin
        dec.r0.last = 1'b1;
      end else begin
        dec.r0    = '{data: CH_NUL, valid: 1'b0, last: 1'b1};
        dec.count = 2'd1;
      end
      dec.pending = 1'b0;
      dec.stopped = 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/command_line_normalizer_unit.sv
// Top level of the command line normaliser: state, decode and a two-slot result buffer.
//
//   channel  direction  handshake                   payload
//   input    in         in_valid / in_ready         in_byte, end_of_string
//   result   out        result_valid / result_ready out_byte, out_valid, out_last
//
// One input byte is accepted per cycle while in_ready is high; its first result is
// registered and offered in the cycle after acceptance. A byte with two results (released
// space plus byte) holds in_ready low until slot 0 pops; the output port sets the rate.
// Reset (synchronous, active high) clears the space and stop flags and empties both slots.
// A stall on the result side backs up into in_ready once the buffer cannot take two beats.
`default_nettype none
module command_line_normalizer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);
  import cln_pkg::*;

  logic    space_pending;
  logic    string_stopped;
  logic    slot0_full;
  logic    slot1_full;
  res_t    slot0;
  res_t    slot1;
  decode_t dec;
  logic    accept;
  logic    pop;

  cln_decode u_decode (
    .in_byte        (in_byte),
    .end_of_string  (end_of_string),
    .space_pending  (space_pending),
    .string_stopped (string_stopped),
    .dec            (dec)
  );

  // An item is taken only when the buffer will be empty after this cycle's beat.
  assign pop      = slot0_full && result_ready;
  assign in_ready = !slot1_full && (!slot0_full || result_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      space_pending  <= 1'b0;
      string_stopped <= 1'b0;
    end else if (accept) begin
      space_pending  <= dec.pending;
      string_stopped <= dec.stopped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot0_full <= 1'b0;
      slot1_full <= 1'b0;
    end else if (accept) begin
      slot0_full <= (dec.count != 2'd0);
      slot1_full <= (dec.count == 2'd2);
    end else if (pop) begin
      slot0_full <= slot1_full;
      slot1_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot0 <= dec.r0;
      slot1 <= dec.r1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign result_valid = slot0_full;
  assign out_byte     = slot0.data;
  assign out_valid    = slot0.valid;
  assign out_last     = slot0.last;

endmodule
`default_nettype wire

FILE: rtl/cln_checker.sv
// Port-level checker for the command line normaliser, bound to the top level.
`default_nettype none
`include "command_line_normalizer_unit_assert.svh"
module cln_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire [7:0] in_byte,
  input wire       end_of_string,
  input wire       result_valid,
  input wire       result_ready,
  input wire [7:0] out_byte,
  input wire       out_valid,
  input wire       out_last
);
  import cln_pkg::*;

  logic in_seen;
  assign in_seen = in_valid && in_ready && (in_byte == in_byte) && (end_of_string == end_of_string);

  // A stalled result beat keeps its payload.
  `CLN_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready && !in_seen, result_valid && $stable(out_byte) && $stable(out_last) && $stable(out_valid))

  // The empty marker is only ever the final beat of a string, with a zero byte.
  `CLN_ASSERT_IMPLY(a_empty_marker, clk, rst, result_valid && !out_valid, out_last && out_byte == CH_NUL)

  // Quote, backslash and caret bytes never reach the output.
  `CLN_ASSERT_IMPLY(a_no_dropped, clk, rst, result_valid && out_valid, out_byte != CH_DQUOTE && out_byte != CH_SQUOTE && out_byte != CH_BSLASH && out_byte != CH_CARET)

  // Output is lower case and separators other than space are folded away.
  `CLN_ASSERT_IMPLY(a_folded, clk, rst, result_valid && out_valid, (out_byte < CH_UPPER_A || out_byte > CH_UPPER_Z) && out_byte != CH_COMMA && out_byte != CH_SEMI && out_byte != CH_TAB && out_byte != CH_CR && out_byte != CH_LF && out_byte != CH_NUL)

endmodule

bind command_line_normalizer_unit cln_checker u_cln_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_command_line_normalizer_unit.sv
// Self-checking testbench for the command line normaliser: directed and random strings with random gaps.
`default_nettype none
module tb_command_line_normalizer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cln_pkg::*;

  typedef logic [7:0] byte_string_t[$];

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       end_of_string;
  logic       result_valid;
  logic       result_ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  // Normaliser state as predicted from the accepted bytes.
  logic space_held;
  logic string_ended;
  res_t normalized_q[$];

  int   mismatch_count;
  int   bytes_sent;
  int   beats_taken;
  bit   sender_idles;
  bit   receiver_stalls;

  command_line_normalizer_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Works out the beats that one accepted byte produces and queues them.
  task automatic normalize_byte(input logic [7:0] b, input logic eos);
    res_t beat_q[$];
    res_t beat;
    logic [7:0] lowered;
    lowered = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
    if (!string_ended) begin
      case (b)
        CH_NUL: string_ended = 1'b1;
        CH_DQUOTE, CH_SQUOTE, CH_BSLASH, CH_CARET: ;
        CH_SPACE, CH_COMMA, CH_SEMI, CH_TAB, CH_CR, CH_LF: space_held = 1'b1;
        CH_SLASH, CH_LPAREN: begin
          space_held = 1'b0;
          beat_q.push_back('{data: b, valid: 1'b1, last: 1'b0});
        end
        default: begin
          if (space_held) begin
            beat_q.push_back('{data: CH_SPACE, valid: 1'b1, last: 1'b0});
          end
          space_held = 1'b0;
          beat_q.push_back('{data: lowered, valid: 1'b1, last: 1'b0});
        end
      endcase
    end
    if (eos) begin
      if (space_held) begin
        beat_q.push_back('{data: CH_SPACE, valid: 1'b1, last: 1'b1});
      end else if (beat_q.size() > 0) begin
        beat = beat_q.pop_back();
        beat.last = 1'b1;
        beat_q.push_back(beat);
      end else begin
        beat_q.push_back('{data: CH_NUL, valid: 1'b0, last: 1'b1});
      end
      space_held   = 1'b0;
      string_ended = 1'b0;
    end
    foreach (beat_q[i]) normalized_q.push_back(beat_q[i]);
  endtask

  // Result beats are checked before the byte accepted on the same edge is predicted.
  always @(posedge clk) begin : check_and_predict
    res_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (normalized_q.size() == 0) begin
          $error("unexpected beat: out_byte %h out_valid %b out_last %b",
                 out_byte, out_valid, out_last);
          mismatch_count++;
        end else begin
          want = normalized_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, out_byte);
            mismatch_count++;
          end
          if (out_valid !== want.valid) begin
            $error("out_valid: expected %b, actual %b", want.valid, out_valid);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %b, actual %b", want.last, out_last);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) normalize_byte(in_byte, end_of_string);
    end
  end

  // Result side: a random stall before each beat, with stretches of none.
  initial begin : result_sink
    int stall;
    result_ready = 1'b0;
    forever begin
      stall = receiver_stalls ? $urandom_range(0, 12) : 0;
      @(negedge clk);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      beats_taken++;
      if (beats_taken % 40 == 0) receiver_stalls = 1'($urandom_range(0, 1));
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = sender_idles ? $urandom_range(0, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (bytes_sent % 50 == 0) sender_idles = 1'($urandom_range(0, 1));
  endtask

  task automatic send_string(input byte_string_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  function automatic logic [7:0] pick_command_byte();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      b = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
    end else if (r < 45) begin
      b = 8'($urandom_range(8'h21, 8'h7E));
    end else if (r < 60) begin
      case ($urandom_range(0, 5))
        0: b = CH_SPACE;
        1: b = CH_COMMA;
        2: b = CH_SEMI;
        3: b = CH_TAB;
        4: b = CH_CR;
        default: b = CH_LF;
      endcase
    end else if (r < 70) begin
      case ($urandom_range(0, 3))
        0: b = CH_DQUOTE;
        1: b = CH_SQUOTE;
        2: b = CH_BSLASH;
        default: b = CH_CARET;
      endcase
    end else if (r < 80) begin
      b = $urandom_range(0, 1) ? CH_SLASH : CH_LPAREN;
    end else if (r < 83) begin
      b = CH_NUL;
    end else begin
      b = 8'($urandom_range(1, 255));
    end
    return b;
  endfunction

  // Case folding, separator runs, dropped bytes, pass-through bytes and string ends.
  task automatic test_directed_cases();
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    // A run broken only by a dropped byte, then a plain last byte releasing the space.
    send_string({8'h41, CH_SPACE, CH_COMMA, CH_DQUOTE, CH_SEMI, 8'h5A});
    // Slash and parenthesis swallow the space; a trailing separator is flushed at the end.
    send_string({CH_TAB, CH_SLASH, CH_LF, CH_LPAREN, 8'hFF, CH_CR});
    // Bytes either side of the letter range, then a dropped last byte, so the end is the empty marker.
    send_string({8'h40, 8'h5B, CH_SQUOTE, CH_BSLASH, CH_CARET});
    // Bytes after a zero are discarded, but the pending space survives to the mark.
    send_string({8'h61, CH_SPACE, CH_NUL, 8'h42, CH_NUL});
    send_string({CH_NUL});
    send_string({8'h7A, 8'h01});
  endtask

  // Well-formed command strings with random content, mostly short.
  task automatic test_command_strings(input int n_bytes);
    byte_string_t s;
    int len;
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      s.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      repeat (len) s.push_back(pick_command_byte());
      send_string(s);
    end
  endtask

  // Arbitrary bytes with the end mark set at random.
  task automatic test_raw_bytes(input int n_bytes);
    repeat (n_bytes - 1) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    end_of_string  = 1'b0;
    space_held     = 1'b0;
    string_ended   = 1'b0;
    mismatch_count = 0;
    bytes_sent     = 0;
    beats_taken    = 0;
    sender_idles   = 1'b1;
    receiver_stalls = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_command_strings(800);
    test_raw_bytes(200);

    @(negedge clk);
    in_valid <= 1'b0;
    while (normalized_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/cln_pkg.sv
rtl/cln_decode.sv
rtl/command_line_normalizer_unit.sv
rtl/cln_checker.sv
tb/sv/tb_command_line_normalizer_unit.sv
